[hw/rtl/calw_pkg.sv]
// Shared types and constants for the card allow-list with lockout.
// Holds opcodes, register indexes, result layout and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package calw_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_DELETE = 2'd2,
		OP_PIN    = 2'd3
	} op_t;

	// register index, taken from paddr[2]
	localparam logic REG_PIN   = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam int          KEY_W          = 32;
	localparam int          LIMIT_W        = 4;
	localparam int          ENT_W          = 5;
	localparam logic [3:0]  FAIL_LIMIT_RST = 4'd3;
	localparam logic [31:0] PIN_RST        = 32'd0;

	typedef struct packed {
		logic load;
		logic search;
		logic shift;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit;
		logic exhausted;
		logic del_op;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic [ENT_W-1:0] entries_now;
		logic             rejected_full;
		logic             found;
		logic             alarm;
		logic             granted;
	} result_t;

endpackage

[hw/rtl/card_allow_list_with_lockout.sv]
// Card allow-list with failure lockout, one request at a time; uses calw_pkg, calw_ctrl, calw_dp.
// Add and PIN go straight to the result; lookup and delete walk the list until a hit or the end,
// and a delete that hits then shifts each later entry down one place. The walk does one memory
// read per cycle; the next request is taken the cycle after the result loads, and a result not
// yet taken holds the block. Reset empties the list, tally 0, PIN 0, limit 3.
`timescale 1ns / 1ps

module card_allow_list_with_lockout #(
	parameter int LIST_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] card_key, [63:32] pin_guess
	input  logic [1:0]  s_tuser,  // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [0] granted, [1] alarm, [2] found,
	                              // [3] rejected_full, [8:4] entries_now, rest zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import calw_pkg::*;

	logic [KEY_W-1:0]   pin_q;
	logic [LIMIT_W-1:0] limit_q;
	ctrl_cmd_t          cmd;
	dp_stat_t           stat;
	result_t            res;
	op_t                in_op;

	assign pready = 1'b1;
	assign in_op  = op_t'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q   <= PIN_RST;
			limit_q <= FAIL_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_PIN) begin
				pin_q <= pwdata;
			end else begin
				limit_q <= pwdata[LIMIT_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_LIMIT) begin
			prdata = {28'd0, limit_q};
		end else begin
			prdata = pin_q;
		end
	end

	calw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (in_op),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	calw_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (in_op),
		.in_key     (s_tdata[31:0]),
		.in_guess   (s_tdata[63:32]),
		.pin_value  (pin_q),
		.fail_limit (limit_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (res)
	);

	assign m_tdata = {7'd0, res.entries_now, res.rejected_full, res.found,
	                  res.alarm, res.granted};

endmodule

[hw/rtl/calw_ctrl.sv]
// Sequencer for the card allow-list: accept, search, shift-down, finish.
// Depends on calw_pkg for opcodes and the command/status structs.
`timescale 1ns / 1ps

module calw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  calw_pkg::op_t       in_op,
	output logic                in_ready,
	input  calw_pkg::dp_stat_t  stat,
	output calw_pkg::ctrl_cmd_t cmd
);
	import calw_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_SHIFT  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_op == OP_LOOKUP || in_op == OP_DELETE) begin
						state_nx = ST_SEARCH;
					end else begin
						state_nx = ST_FINISH;
					end
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.hit) begin
					state_nx = stat.del_op ? ST_SHIFT : ST_FINISH;
				end else if (stat.exhausted) begin
					state_nx = ST_FINISH;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.exhausted) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output register can take the result
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/calw_dp.sv]
// Datapath for the card allow-list: card memory, walk index, counters, result register.
// Depends on calw_pkg; driven by calw_ctrl commands.
`timescale 1ns / 1ps

module calw_dp #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  calw_pkg::ctrl_cmd_t          cmd,
	output calw_pkg::dp_stat_t           stat,
	input  calw_pkg::op_t                in_op,
	input  logic [calw_pkg::KEY_W-1:0]   in_key,
	input  logic [calw_pkg::KEY_W-1:0]   in_guess,
	input  logic [calw_pkg::KEY_W-1:0]   pin_value,
	input  logic [calw_pkg::LIMIT_W-1:0] fail_limit,
	output logic                         out_valid,
	input  logic                         out_ready,
	output calw_pkg::result_t            out_data
);
	import calw_pkg::*;

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

	logic [KEY_W-1:0] mem [LIST_DEPTH];
	logic [KEY_W-1:0] rd_s1;
	logic [AW-1:0]    pidx_s1;
	logic             pend_s1;

	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] guess_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    count_q;
	logic [LIMIT_W-1:0] tally_q;
	logic             found_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             issue;
	logic             hit;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic             full;
	logic             judge_en;
	logic             ok;
	logic             fail_trip;
	logic [CW-1:0]    count_nx;
	logic [31:0]      count_wide;

	assign full   = (count_q == DEPTH_C);
	assign issue  = (cmd.search || cmd.shift) && (idx_q < count_q);
	assign hit    = cmd.search && pend_s1 && (rd_s1 == key_q);

	assign stat.hit       = hit;
	assign stat.exhausted = !pend_s1 && !(idx_q < count_q);
	assign stat.del_op    = (op_q == OP_DELETE);
	assign stat.out_free  = !out_valid_q || out_ready;

	// single write port: append on finish of an add, move down during shift
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		if (cmd.shift && pend_s1) begin
			wr_en   = 1'b1;
			wr_addr = pidx_s1 - AW'(1);
		end else if (cmd.finish && op_q == OP_ADD && !full) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= (cmd.shift) ? rd_s1 : key_q;
		end
		if (issue) begin
			rd_s1 <= mem[idx_q[AW-1:0]];
		end
		if (issue) begin
			pidx_s1 <= idx_q[AW-1:0];
		end
		if (cmd.load) begin
			op_q    <= in_op;
			key_q   <= in_key;
			guess_q <= in_guess;
		end
	end

	assign judge_en  = (op_q == OP_LOOKUP) || (op_q == OP_PIN);
	assign ok        = (op_q == OP_LOOKUP) ? found_q : (guess_q == pin_value);
	assign fail_trip = ({1'b0, tally_q} + 5'd1) >= {1'b0, fail_limit};

	always_comb begin
		count_nx = count_q;
		if (op_q == OP_ADD && !full) begin
			count_nx = count_q + CW'(1);
		end else if (op_q == OP_DELETE && found_q) begin
			count_nx = count_q - CW'(1);
		end
	end

	assign count_wide = 32'(count_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			count_q     <= '0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
				found_q <= 1'b0;
			end else if (hit) begin
				// drop the read in flight and restart the walk past the match
				found_q <= 1'b1;
				pend_s1 <= 1'b0;
				idx_q   <= CW'(pidx_s1) + CW'(1);
			end else begin
				pend_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
			end

			if (cmd.finish) begin
				count_q <= count_nx;
				if (judge_en) begin
					if (ok || fail_trip) begin
						tally_q <= '0;
					end else begin
						tally_q <= tally_q + LIMIT_W'(1);
					end
				end
			end

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.granted       <= judge_en && ok;
			out_q.alarm         <= judge_en && !ok && fail_trip;
			out_q.found         <= (op_q == OP_LOOKUP || op_q == OP_DELETE) && found_q;
			out_q.rejected_full <= (op_q == OP_ADD) && full;
			out_q.entries_now   <= count_wide[ENT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
